// ----- rtl/utf8_to_utf16_transcoder_macros.svh -----
// Assertion macros shared by the UTF-8 to UTF-16 transcoder RTL.
// Standalone header; included by files that carry concurrent assertions.
`ifndef UTF8_TO_UTF16_TRANSCODER_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define U8U16_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define U8U16_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/u8u16_pkg.sv -----
// Package for the UTF-8 to UTF-16 transcoder: byte class limits, masks,
// surrogate constants and the per-byte decode function. No dependencies.
package u8u16_pkg;

  localparam int unsigned PointWidth = 21;
  localparam int unsigned UnitWidth  = 16;

  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] CONT_MAX  = 8'hBF;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;

  localparam logic [7:0] LEAD2_MASK = 8'h1F;
  localparam logic [7:0] LEAD3_MASK = 8'h0F;
  localparam logic [7:0] LEAD4_MASK = 8'h07;

  localparam logic [PointWidth-1:0] PAIR_BASE = 21'h10000;
  localparam logic [UnitWidth-1:0]  HI_SURR   = 16'hD800;
  localparam logic [UnitWidth-1:0]  LO_SURR   = 16'hDC00;

  // Outcome of one byte: whether a code point completes, and the new state.
  typedef struct packed {
    logic                  emit;
    logic [PointWidth-1:0] point;
    logic [1:0]            pend;
    logic [PointWidth-1:0] acc;
  } dec_t;

  function automatic dec_t decode(
    input logic [7:0]            b,
    input logic                  start,
    input logic [1:0]            pend,
    input logic [PointWidth-1:0] acc
  );
    dec_t                  d;
    logic [1:0]            pend_eff;
    logic [PointWidth-1:0] acc_eff;
    logic [PointWidth-1:0] acc_shift;
    pend_eff  = start ? 2'd0 : pend;
    acc_eff   = start ? '0 : acc;
    acc_shift = {acc_eff[PointWidth-7:0], b[5:0]};
    d.emit  = 1'b0;
    d.point = '0;
    d.pend  = pend_eff;
    d.acc   = acc_eff;
    if (pend_eff != 2'd0) begin
      // Inside a sequence every byte counts as a continuation byte.
      d.acc   = acc_shift;
      d.pend  = pend_eff - 2'd1;
      d.emit  = (pend_eff == 2'd1);
      d.point = acc_shift;
    end else if (b <= ASCII_MAX) begin
      d.emit  = 1'b1;
      d.point = {13'd0, b};
    end else if (b <= CONT_MAX) begin
      // Stray continuation byte is dropped and the state is left alone.
      d.emit = 1'b0;
    end else if (b <= LEAD2_MAX) begin
      d.acc  = {13'd0, b & LEAD2_MASK};
      d.pend = 2'd1;
    end else if (b <= LEAD3_MAX) begin
      d.acc  = {13'd0, b & LEAD3_MASK};
      d.pend = 2'd2;
    end else begin
      d.acc  = {13'd0, b & LEAD4_MASK};
      d.pend = 2'd3;
    end
    return d;
  endfunction

endpackage

// ----- rtl/utf8_to_utf16_transcoder.sv -----
// Top level of the lenient UTF-8 to UTF-16 transcoder.
// Depends on u8u16_pkg and utf8_to_utf16_transcoder_macros.svh.
//
// The block takes one UTF-8 byte per slave transaction and gives UTF-16 code
// units on the master side. A byte is registered on entry; while it waits there
// the decode logic combines it with the pending-byte count and the code point
// accumulator, and, once there is room, any finished code unit is loaded into
// the output register. The first unit of an accepted byte thus passes through
// the entry register and the output register before the master side shows it.
// One byte is taken every cycle while the master side keeps up and no pair
// half waits. A code point above 0xFFFF yields a surrogate pair: the high half
// goes out first with tlast low, the low half is held in a second register and
// follows with tlast high, and the entry register waits until the low half has
// moved into the output register. tlast is high on the final unit caused by a
// byte. tuser high marks the first byte of a message and discards any
// unfinished sequence. Bytes that give no unit (lead bytes, continuations,
// stray continuations) still pass through the entry register at one per cycle
// while there is room. Decoding is lenient: no overlong, surrogate or range
// checks are made.
module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tuser,   // [0] msg_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] code_unit
  output logic        m_tlast    // last_unit
);

  `include "utf8_to_utf16_transcoder_macros.svh"

  // Entry register.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;

  // Decode state.
  logic [1:0]            bytes_pending;
  logic [PointWidth-1:0] point_accum;

  // Second half of a surrogate pair, waiting behind the output register.
  logic                 sec_valid;
  logic [UnitWidth-1:0] sec_data;

  dec_t                  dec;
  logic                  room;
  logic                  advance;
  logic                  is_pair;
  logic [PointWidth-1:0] offset;
  logic [UnitWidth-1:0]  unit_hi;
  logic [UnitWidth-1:0]  unit_lo;

  // The result stage can take a new byte's units when no pair half waits and
  // the output register is empty or being emptied in this cycle.
  assign room     = !sec_valid && (!m_tvalid || m_tready);
  assign advance  = in_valid && room;
  assign s_tready = !in_valid || advance;

  assign dec     = decode(in_byte, in_start, bytes_pending, point_accum);
  assign is_pair = |dec.point[PointWidth-1:UnitWidth];
  assign offset  = dec.point - PAIR_BASE;
  assign unit_hi = HI_SURR | {5'd0, offset[PointWidth-1:10]};
  assign unit_lo = LO_SURR | {6'd0, offset[9:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      point_accum   <= '0;
    end else if (advance) begin
      bytes_pending <= dec.pend;
      point_accum   <= dec.acc;
    end
  end

  // Output control: a new byte's units load only when there is room (see
  // above); otherwise a taken unit is replaced by the waiting pair half, if
  // any.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      sec_valid <= 1'b0;
    end else if (advance && dec.emit) begin
      m_tvalid  <= 1'b1;
      sec_valid <= is_pair;
    end else if (m_tvalid && m_tready) begin
      if (sec_valid) begin
        sec_valid <= 1'b0;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && m_tready && sec_valid) begin
      m_tdata <= sec_data;
      m_tlast <= 1'b1;
    end
    if (advance && dec.emit) begin
      m_tdata  <= is_pair ? unit_hi : dec.point[UnitWidth-1:0];
      m_tlast  <= !is_pair;
      sec_data <= unit_lo;
    end
  end

  // A waiting low half always sits behind a shown high half.
  `U8U16_ASSERT_NOW(a_pair_behind_output, clk, rst, sec_valid, m_tvalid && !m_tlast, "pair half without high half on output")
  // The waiting half is a low surrogate; points past 0x10FFFF may set bit 10 of the high half.
  `U8U16_ASSERT_NOW(a_pair_surrogates, clk, rst, sec_valid, (m_tdata[15:11] == 5'b11011) && (sec_data[15:10] == 6'b110111), "surrogate pair malformed")
  // A taken high half is followed by its low half as the final unit.
  `U8U16_ASSERT_NEXT(a_pair_follows, clk, rst, sec_valid && m_tready, m_tvalid && m_tlast && !sec_valid, "low half did not follow high half")

endmodule
